// ===== rtl/cfd_pkg.sv =====
// Shared types and constants for the candle feature and direction block.
// Used by every module under rtl; depends on nothing else.
package cfd_pkg;

	localparam int RangeWindow = 20;
	localparam int IdxW        = 5;
	localparam int LagMid      = 5;
	localparam int LagLong     = 20;
	localparam int AtrSpan     = 10;
	localparam int NumRegs     = 7;
	localparam int NumFeat     = 6;
	localparam int DivBits     = 56;
	localparam int DenBits     = 40;
	localparam int HalfQ16     = 32768;
	localparam int OneQ16      = 65536;
	localparam int VolFloor    = 13107;

	localparam logic [2:0] RegBias    = 3'd0;
	localparam logic [2:0] RegWeightPos = 3'd1;
	localparam logic [2:0] RegWeightR1  = 3'd2;
	localparam logic [2:0] RegWeightR5  = 3'd3;
	localparam logic [2:0] RegWeightR20 = 3'd4;
	localparam logic [2:0] RegWeightVol = 3'd5;
	localparam logic [2:0] RegWeightAtr = 3'd6;

	typedef struct packed {
		logic        warm;
		logic [31:0] high;
		logic [31:0] low;
		logic [31:0] close;
		logic [31:0] volume;
	} item_t;

	typedef struct packed {
		logic               start;
		logic [DivBits-1:0] num;
		logic [DenBits-1:0] den;
	} div_req_t;

endpackage

// ===== rtl/candle_feature_direction_core.sv =====
// Top level of the candle feature and direction block.
// Depends on cfd_pkg, cfd_front, cfd_queue, cfd_div and cfd_back.
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+---------------------------
//  s_*     | s_tvalid s_tready s_tdata[127:0]         | one candle per transfer
//  m_*     | m_tvalid m_tready m_tdata[199:0]         | six features and direction
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data   | weight and bias writes
//
// The computing side takes a candle from the queue when it is idle. A warm-up candle
// then goes straight to the score and the output load.
// A full candle first scans the 20-candle window, then runs six divisions in the
// shared divider, which produces one quotient bit per cycle, and then computes the
// score and loads the output. A division with a zero or negative divisor is skipped.
// Reset clears control state, the warm-up count and the weight registers.
// Two candles can wait in the queue while a finished result stalls on m_tready.
module candle_feature_direction_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // candle_high, candle_low, candle_close, candle_volume
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [199:0] m_tdata,   // range_position, return_one, return_five,
	                                // return_twenty, volume_ratio, volatility, direction_up
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic                        push;
	logic                        q_full;
	logic                        q_empty;
	logic                        q_pop;
	cfd_pkg::item_t              push_item;
	cfd_pkg::item_t              q_head;
	cfd_pkg::div_req_t           div_req;
	logic                        div_done;
	logic [cfd_pkg::DivBits-1:0] div_quo;

	cfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	cfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	cfd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	cfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_quo   (div_quo)
	);

endmodule

// ===== rtl/cfd_front.sv =====
// Input side: takes candle transfers, tags warm-up items by a saturating count.
// Depends on cfd_pkg.
module cfd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [127:0]   s_tdata,
	input  logic           q_full,
	output logic           push,
	output cfd_pkg::item_t push_item
);

	logic [cfd_pkg::IdxW-1:0] seen_q;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		push_item.warm   = seen_q < cfd_pkg::IdxW'(cfd_pkg::RangeWindow);
		push_item.high   = s_tdata[31:0];
		push_item.low    = s_tdata[63:32];
		push_item.close  = s_tdata[95:64];
		push_item.volume = s_tdata[127:96];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push && push_item.warm) begin
			seen_q <= seen_q + 1'b1;
		end
	end

endmodule

// ===== rtl/cfd_queue.sv =====
// Two-entry queue between the input side and the computing side.
// Depends on cfd_pkg for the item type.
module cfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output cfd_pkg::item_t head
);

	cfd_pkg::item_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

endmodule

// ===== rtl/cfd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on cfd_pkg for widths and the request type.
module cfd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfd_pkg::div_req_t           req,
	output logic                        done,
	output logic [cfd_pkg::DivBits-1:0] quo
);

	localparam int CntW = $clog2(cfd_pkg::DivBits);

	logic [CntW-1:0]             cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [cfd_pkg::DenBits-1:0] rem_q;
	logic [cfd_pkg::DenBits-1:0] den_q;
	logic [cfd_pkg::DivBits-1:0] dq_q;
	logic [cfd_pkg::DenBits:0]   rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q, dq_q[cfd_pkg::DivBits-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign done   = done_q;
	assign quo    = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(cfd_pkg::DivBits - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(cfd_pkg::DivBits - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= cfd_pkg::DenBits'(rem_sh - {1'b0, den_q});
				dq_q  <= {dq_q[cfd_pkg::DivBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[cfd_pkg::DenBits-1:0];
				dq_q  <= {dq_q[cfd_pkg::DivBits-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== rtl/cfd_back.sv =====
// Computing side: candle history, window scan, feature divisions, linear score,
// output register and the weight registers. Depends on cfd_pkg and cfd_div.
module cfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  cfd_pkg::item_t              q_head,
	output logic                        q_pop,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [199:0]                m_tdata,
	output cfd_pkg::div_req_t           div_req,
	input  logic                        div_done,
	input  logic [cfd_pkg::DivBits-1:0] div_quo
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_DRAIN  = 4'd2;
	localparam logic [3:0] ST_PREP   = 4'd3;
	localparam logic [3:0] ST_START  = 4'd4;
	localparam logic [3:0] ST_WAIT   = 4'd5;
	localparam logic [3:0] ST_SCORE  = 4'd6;
	localparam logic [3:0] ST_SDRAIN = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	localparam int IdxW = cfd_pkg::IdxW;
	localparam logic [IdxW-1:0] LastIdx  = IdxW'(cfd_pkg::RangeWindow - 1);
	localparam logic [IdxW-1:0] MidIdx   = IdxW'(cfd_pkg::LagMid - 1);
	localparam logic [IdxW-1:0] LongIdx  = IdxW'(cfd_pkg::LagLong - 1);
	localparam logic [IdxW-1:0] AtrIdx   = IdxW'(cfd_pkg::AtrSpan);
	localparam logic [2:0] LastOp   = 3'(cfd_pkg::NumFeat - 1);
	localparam logic [2:0] LastTerm = 3'(cfd_pkg::NumFeat);
	localparam logic signed [57:0] SatHi = 58'sd2147483647;
	localparam logic signed [57:0] SatLo = -58'sd2147483648;
	localparam logic signed [31:0] Half  = 32'(cfd_pkg::HalfQ16);
	localparam logic signed [31:0] One   = 32'(cfd_pkg::OneQ16);

	// Control
	logic [3:0]      state_q;
	logic [IdxW-1:0] scan_i_q;
	logic            rd_valid_q;
	logic [2:0]      op_q;
	logic [2:0]      t_q;
	logic            pv_q;
	logic            m_tvalid_q;
	logic signed [15:0] cfg_q [cfd_pkg::NumRegs];

	// Payload
	logic [31:0] hist_h [cfd_pkg::RangeWindow];
	logic [31:0] hist_l [cfd_pkg::RangeWindow];
	logic [31:0] hist_c [cfd_pkg::RangeWindow];
	logic [31:0] hist_v [cfd_pkg::RangeWindow];
	logic [IdxW-1:0] rd_i_q;
	logic [31:0] rd_h_q, rd_l_q, rd_c_q, rd_v_q, ph_q, pl_q;
	logic [31:0] cur_h_q, cur_l_q, cur_c_q, cur_v_q;
	logic [31:0] hi_q, lo_q, c1_q, c5_q, c20_q;
	logic [36:0] vsum_q;
	logic [35:0] trsum_q;
	logic signed [57:0] num_q;
	logic [cfd_pkg::DenBits-1:0] den_q;
	logic        spec_q;
	logic        neg_q;
	logic signed [31:0] spec_val_q;
	logic signed [31:0] feat_q [cfd_pkg::NumFeat];
	logic [2:0]  pt_q;
	logic signed [48:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] out_feat_q [cfd_pkg::NumFeat];
	logic        out_dir_q;

	logic load_out;
	logic accept_item;

	assign cfg_ready   = 1'b1;
	assign m_tvalid    = m_tvalid_q;
	assign accept_item = (state_q == ST_IDLE) && !q_empty;
	assign q_pop       = accept_item;
	assign load_out    = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign m_tdata = {7'd0, out_dir_q, out_feat_q[5], out_feat_q[4], out_feat_q[3],
		out_feat_q[2], out_feat_q[1], out_feat_q[0]};

	// True range of the candle one step newer than the one just read.
	logic signed [32:0] hl_d, hp_d, lp_d, hp_a, lp_a, tr_v;
	always_comb begin
		hl_d = $signed({1'b0, ph_q}) - $signed({1'b0, pl_q});
		hp_d = $signed({1'b0, ph_q}) - $signed({1'b0, rd_c_q});
		lp_d = $signed({1'b0, pl_q}) - $signed({1'b0, rd_c_q});
		hp_a = hp_d[32] ? -hp_d : hp_d;
		lp_a = lp_d[32] ? -lp_d : lp_d;
		tr_v = hl_d;
		if (hp_a > tr_v) tr_v = hp_a;
		if (lp_a > tr_v) tr_v = lp_a;
	end

	// Division operands for the feature selected by op_q.
	logic [31:0]        base;
	logic signed [32:0] diff, range_d;
	logic signed [57:0] dx, num_c;
	logic [cfd_pkg::DenBits-1:0] den_c;
	logic               spec_c;
	logic signed [31:0] spec_val_c;
	always_comb begin
		case (op_q)
			3'd1:    base = c1_q;
			3'd2:    base = c5_q;
			3'd3:    base = c20_q;
			default: base = lo_q;
		endcase
		diff    = $signed({1'b0, cur_c_q}) - $signed({1'b0, base});
		range_d = $signed({1'b0, hi_q}) - $signed({1'b0, lo_q});
		dx      = 58'(diff);
		unique case (op_q)
			3'd0: begin
				num_c      = dx <<< 16;
				den_c      = cfd_pkg::DenBits'(range_d[31:0]);
				spec_c     = range_d[32] || (range_d == 33'sd0);
				spec_val_c = Half;
			end
			3'd1, 3'd2, 3'd3: begin
				// 100 * 2^16 = 2^22 + 2^21 + 2^18
				num_c      = (dx <<< 22) + (dx <<< 21) + (dx <<< 18);
				den_c      = cfd_pkg::DenBits'(base);
				spec_c     = base == 32'd0;
				spec_val_c = 32'sd0;
			end
			3'd4: begin
				num_c      = 58'(cur_v_q) <<< 18;
				den_c      = cfd_pkg::DenBits'(vsum_q);
				spec_c     = vsum_q == 37'd0;
				spec_val_c = 32'(cfd_pkg::VolFloor);
			end
			default: begin
				num_c      = 58'(trsum_q) <<< 16;
				den_c      = cfd_pkg::DenBits'(cur_c_q);
				spec_c     = cur_c_q == 32'd0;
				spec_val_c = 32'sd0;
			end
		endcase
	end

	logic signed [57:0] mag;
	always_comb begin
		mag = num_q[57] ? -num_q : num_q;
		div_req.start = (state_q == ST_START) && !spec_q;
		div_req.num   = mag[cfd_pkg::DivBits-1:0];
		div_req.den   = den_q;
	end

	// Signed quotient, saturated or capped by feature.
	logic signed [57:0] q_ext, res;
	logic signed [31:0] feat_c;
	always_comb begin
		q_ext = $signed({2'b00, div_quo});
		res   = neg_q ? -q_ext : q_ext;
		if (op_q <= 3'd3) begin
			if (res > SatHi) feat_c = 32'sh7fffffff;
			else if (res < SatLo) feat_c = 32'sh80000000;
			else feat_c = res[31:0];
		end else begin
			feat_c = (res > 58'(One)) ? One : res[31:0];
		end
	end

	// Score terms: one product a cycle, scaled and summed the next.
	logic signed [32:0] a_t;
	logic signed [15:0] w_t;
	logic signed [48:0] prod_c;
	logic signed [63:0] pe, scaled;
	always_comb begin
		case (t_q)
			3'd0: begin a_t = 33'sd65536;                    w_t = cfg_q[cfd_pkg::RegBias]; end
			3'd1: begin a_t = 33'(feat_q[0]) - 33'(Half);    w_t = cfg_q[cfd_pkg::RegWeightPos]; end
			3'd2: begin a_t = 33'(feat_q[1]);                w_t = cfg_q[cfd_pkg::RegWeightR1]; end
			3'd3: begin a_t = 33'(feat_q[2]);                w_t = cfg_q[cfd_pkg::RegWeightR5]; end
			3'd4: begin a_t = 33'(feat_q[3]);                w_t = cfg_q[cfd_pkg::RegWeightR20]; end
			3'd5: begin a_t = 33'(feat_q[4]) - 33'(One);     w_t = cfg_q[cfd_pkg::RegWeightVol]; end
			default: begin a_t = 33'(feat_q[5]) - 33'(Half); w_t = cfg_q[cfd_pkg::RegWeightAtr]; end
		endcase
		prod_c = a_t * w_t;
		pe     = 64'(prod_q);
		case (pt_q)
			3'd1, 3'd6: scaled = (pe <<< 7) + (pe <<< 6) + (pe <<< 3);
			3'd2:       scaled = (pe <<< 3) + (pe <<< 1);
			3'd3:       scaled = (pe <<< 2) + pe;
			3'd4:       scaled = pe <<< 1;
			default:    scaled = (pe <<< 6) + (pe <<< 5) + (pe <<< 2);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_i_q   <= '0;
			rd_valid_q <= 1'b0;
			op_q       <= '0;
			t_q        <= '0;
			pv_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < cfd_pkg::NumRegs; i++) cfg_q[i] <= '0;
		end else begin
			if (cfg_valid && (cfg_index < 3'(cfd_pkg::NumRegs))) begin
				cfg_q[cfg_index] <= $signed(cfg_data);
			end
			rd_valid_q <= state_q == ST_SCAN;
			pv_q       <= state_q == ST_SCORE;
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						scan_i_q <= '0;
						t_q      <= '0;
						state_q  <= q_head.warm ? ST_SCORE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_i_q == LastIdx) state_q <= ST_DRAIN;
					else scan_i_q <= scan_i_q + 1'b1;
				end
				ST_DRAIN: begin
					op_q    <= '0;
					state_q <= ST_PREP;
				end
				ST_PREP: state_q <= ST_START;
				ST_START, ST_WAIT: begin
					if ((state_q == ST_START && spec_q) || (state_q == ST_WAIT && div_done)) begin
						if (op_q == LastOp) begin
							t_q     <= '0;
							state_q <= ST_SCORE;
						end else begin
							op_q    <= op_q + 1'b1;
							state_q <= ST_PREP;
						end
					end else if (state_q == ST_START) begin
						state_q <= ST_WAIT;
					end
				end
				ST_SCORE: begin
					if (t_q == LastTerm) state_q <= ST_SDRAIN;
					else t_q <= t_q + 1'b1;
				end
				ST_SDRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_item) begin
			cur_h_q <= q_head.high;
			cur_l_q <= q_head.low;
			cur_c_q <= q_head.close;
			cur_v_q <= q_head.volume;
			hi_q    <= q_head.high;
			lo_q    <= q_head.low;
			vsum_q  <= '0;
			trsum_q <= '0;
			acc_q   <= '0;
			if (q_head.warm) begin
				for (int i = 0; i < cfd_pkg::NumFeat; i++) feat_q[i] <= Half;
			end
		end
		if (state_q == ST_SCAN) begin
			rd_h_q <= hist_h[scan_i_q];
			rd_l_q <= hist_l[scan_i_q];
			rd_c_q <= hist_c[scan_i_q];
			rd_v_q <= hist_v[scan_i_q];
			rd_i_q <= scan_i_q;
		end
		if (rd_valid_q) begin
			if (rd_h_q > hi_q) hi_q <= rd_h_q;
			if (rd_l_q < lo_q) lo_q <= rd_l_q;
			vsum_q <= vsum_q + 37'(rd_v_q);
			if (rd_i_q == '0) c1_q <= rd_c_q;
			if (rd_i_q == MidIdx) c5_q <= rd_c_q;
			if (rd_i_q == LongIdx) c20_q <= rd_c_q;
			if (rd_i_q != '0 && rd_i_q <= AtrIdx) trsum_q <= trsum_q + 36'(tr_v[31:0]);
			ph_q <= rd_h_q;
			pl_q <= rd_l_q;
		end
		if (state_q == ST_PREP) begin
			num_q      <= num_c;
			den_q      <= den_c;
			spec_q     <= spec_c;
			spec_val_q <= spec_val_c;
		end
		if (state_q == ST_START) begin
			neg_q <= num_q[57];
			if (spec_q) feat_q[op_q] <= spec_val_q;
		end
		if (state_q == ST_WAIT && div_done) feat_q[op_q] <= feat_c;
		if (state_q == ST_SCORE) begin
			prod_q <= prod_c;
			pt_q   <= t_q;
		end
		if (pv_q) acc_q <= acc_q + scaled;
		if (load_out) begin
			for (int i = 0; i < cfd_pkg::NumFeat; i++) out_feat_q[i] <= feat_q[i];
			out_dir_q <= acc_q > 64'sd0;
			hist_h[0] <= cur_h_q;
			hist_l[0] <= cur_l_q;
			hist_c[0] <= cur_c_q;
			hist_v[0] <= cur_v_q;
			for (int i = 1; i < cfd_pkg::RangeWindow; i++) begin
				hist_h[i] <= hist_h[i-1];
				hist_l[i] <= hist_l[i-1];
				hist_c[i] <= hist_c[i-1];
				hist_v[i] <= hist_v[i-1];
			end
		end
	end

endmodule

// ===== test/tb_candle_feature_direction_core.sv =====
// Testbench for candle_feature_direction_core: drives candles and weight writes and
// checks every feature and the direction bit against a predictor of the block.
// Depends on cfd_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module tb_candle_feature_direction_core;

	typedef struct packed {
		logic [31:0] high;
		logic [31:0] low;
		logic [31:0] close;
		logic [31:0] volume;
	} candle_t;

	// Listed from the top bit down, so pos sits in the lowest 32 bits of tdata.
	typedef struct packed {
		logic        up;
		logic [31:0] atr;
		logic [31:0] vol;
		logic [31:0] r20;
		logic [31:0] r5;
		logic [31:0] r1;
		logic [31:0] pos;
	} feature_t;

	localparam int HoldLen = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [199:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	candle_feature_direction_core dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state.
	logic [31:0] hist_high [cfd_pkg::RangeWindow];
	logic [31:0] hist_low [cfd_pkg::RangeWindow];
	logic [31:0] hist_close [cfd_pkg::RangeWindow];
	logic [31:0] hist_vol [cfd_pkg::RangeWindow];
	int unsigned slot_next = 0;
	int unsigned seen_count = 0;
	logic [15:0] weights [cfd_pkg::NumRegs];

	feature_t pending_features[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 57;
	bit hold_on = 1'b0;
	bit hold_done = 1'b0;
	int hold_count = 0;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint pct_change(longint now_c, longint then_c);
		if (then_c == 0) return 0;
		return sat32((now_c - then_c) * 100 * cfd_pkg::OneQ16 / then_c);
	endfunction

	function automatic int unsigned back_slot(int unsigned k);
		return (slot_next + cfd_pkg::RangeWindow - k) % cfd_pkg::RangeWindow;
	endfunction

	function automatic longint wsext(int r);
		return longint'(signed'(weights[r]));
	endfunction

	function automatic feature_t predict_features(candle_t cd);
		longint h, l, c, v, hi, lo, vsum, trsum, th, tl, pc, tr, a, score;
		longint f [cfd_pkg::NumFeat];
		int unsigned s;
		feature_t r;
		h = cd.high; l = cd.low; c = cd.close; v = cd.volume;
		if (seen_count < cfd_pkg::RangeWindow) begin
			foreach (f[j]) f[j] = cfd_pkg::HalfQ16;
		end else begin
			hi = h; lo = l; vsum = 0; trsum = 0;
			for (int k = 1; k <= cfd_pkg::RangeWindow; k++) begin
				s = back_slot(k);
				if (longint'(hist_high[s]) > hi) hi = hist_high[s];
				if (longint'(hist_low[s]) < lo) lo = hist_low[s];
				vsum += hist_vol[s];
			end
			f[0] = (hi - lo > 0) ? sat32((c - lo) * cfd_pkg::OneQ16 / (hi - lo))
				: cfd_pkg::HalfQ16;
			f[1] = pct_change(c, hist_close[back_slot(1)]);
			f[2] = pct_change(c, hist_close[back_slot(cfd_pkg::LagMid)]);
			f[3] = pct_change(c, hist_close[back_slot(cfd_pkg::LagLong)]);
			if (vsum > 0) begin
				f[4] = v * 4 * cfd_pkg::OneQ16 / vsum;
				if (f[4] > cfd_pkg::OneQ16) f[4] = cfd_pkg::OneQ16;
			end else f[4] = cfd_pkg::VolFloor;
			for (int k = 1; k <= cfd_pkg::AtrSpan; k++) begin
				s = back_slot(k);
				th = hist_high[s]; tl = hist_low[s];
				pc = hist_close[back_slot(k + 1)];
				tr = th - tl;
				a = th - pc; if (a < 0) a = -a;
				if (a > tr) tr = a;
				a = tl - pc; if (a < 0) a = -a;
				if (a > tr) tr = a;
				trsum += tr;
			end
			if (c != 0) begin
				f[5] = trsum * cfd_pkg::OneQ16 / c;
				if (f[5] > cfd_pkg::OneQ16) f[5] = cfd_pkg::OneQ16;
			end else f[5] = 0;
		end
		// Score is scaled by 100 * 2^28 so every term stays an integer.
		score = wsext(cfd_pkg::RegBias) * cfd_pkg::OneQ16 * 100;
		score += (f[0] - cfd_pkg::HalfQ16) * wsext(cfd_pkg::RegWeightPos) * 200;
		score += f[1] * wsext(cfd_pkg::RegWeightR1) * 10;
		score += f[2] * wsext(cfd_pkg::RegWeightR5) * 5;
		score += f[3] * wsext(cfd_pkg::RegWeightR20) * 2;
		score += (f[4] - cfd_pkg::OneQ16) * wsext(cfd_pkg::RegWeightVol) * 100;
		score += (f[5] - cfd_pkg::HalfQ16) * wsext(cfd_pkg::RegWeightAtr) * 200;
		r.pos = f[0][31:0]; r.r1 = f[1][31:0]; r.r5 = f[2][31:0];
		r.r20 = f[3][31:0]; r.vol = f[4][31:0]; r.atr = f[5][31:0];
		r.up = score > 0;
		hist_high[slot_next] = cd.high;
		hist_low[slot_next] = cd.low;
		hist_close[slot_next] = cd.close;
		hist_vol[slot_next] = cd.volume;
		slot_next = (slot_next + 1) % cfd_pkg::RangeWindow;
		if (seen_count < cfd_pkg::RangeWindow) seen_count++;
		return r;
	endfunction

	// Receiver: stalls at random, or once for a long stretch after hold_on is set.
	always @(negedge clk) begin
		if (hold_on && !hold_done) begin
			m_tready <= 1'b0;
			if (hold_count == HoldLen - 1) hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		feature_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[192:0];
			if (pending_features.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_features.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pos %h r1 %h r5 %h r20 %h vol %h atr %h up %b",
							want.pos, want.r1, want.r5, want.r20, want.vol, want.atr,
							want.up, "\n          got pos %h r1 %h r5 %h r20 %h vol %h atr %h up %b",
							got.pos, got.r1, got.r5, got.r20, got.vol, got.atr, got.up);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic write_weight(input logic [2:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		weights[idx] = val;
		@(negedge clk);
	endtask

	task automatic send_candle(input candle_t cd);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {cd.volume, cd.close, cd.low, cd.high};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_features.push_back(predict_features(cd));
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_features.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_price(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(1000, 1100);
			2: return $urandom_range(0, 3);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 50);
		endcase
	endfunction

	function automatic candle_t rand_candle(int mode);
		candle_t cd;
		logic [31:0] base;
		base = rand_price(mode);
		if ($urandom_range(9) == 0) begin
			cd.high = rand_price(mode); cd.low = rand_price(mode);
			cd.close = rand_price(mode);
		end else begin
			cd.close = base;
			cd.high = (base > 32'hFFFF_FF00) ? 32'hFFFF_FFFF : base + $urandom_range(0, 40);
			cd.low = (base < 40) ? 32'd0 : base - $urandom_range(0, 40);
		end
		case ($urandom_range(3))
			0: cd.volume = $urandom();
			1: cd.volume = $urandom_range(0, 1000);
			2: cd.volume = 0;
			default: cd.volume = 32'hFFFF_FFFF - $urandom_range(0, 5);
		endcase
		return cd;
	endfunction

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return $urandom();
		endcase
	endfunction

	// Directed candles; all are warm-up, so each feature is one half.
	candle_t directed [12] = '{
		'{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'h0, 32'h0, 32'h0, 32'h0},
		'{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1},
		'{32'd100, 32'd100, 32'd100, 32'd0},
		'{32'd200, 32'd100, 32'd150, 32'd10},
		'{32'd200, 32'd100, 32'd300, 32'd10},
		'{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA},
		'{32'd1, 32'd1, 32'd1, 32'd1},
		'{32'd1000, 32'd900, 32'd950, 32'd500},
		'{32'd1000, 32'd900, 32'd0, 32'd500},
		'{32'd10, 32'd20, 32'd15, 32'd7},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}
	};

	initial begin
		feature_t want;
		feature_t warm_want;
		candle_t cd;
		int mode;
		warm_want.pos = 32'(cfd_pkg::HalfQ16);
		warm_want.r1 = 32'(cfd_pkg::HalfQ16);
		warm_want.r5 = 32'(cfd_pkg::HalfQ16);
		warm_want.r20 = 32'(cfd_pkg::HalfQ16);
		warm_want.vol = 32'(cfd_pkg::HalfQ16);
		warm_want.atr = 32'(cfd_pkg::HalfQ16);
		warm_want.up = 1'b0;
		foreach (weights[i]) weights[i] = '0;
		foreach (hist_high[i]) begin
			hist_high[i] = '0; hist_low[i] = '0; hist_close[i] = '0; hist_vol[i] = '0;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset weights: score is zero, so direction is down, and every feature is one half.
		foreach (directed[i]) begin
			want = predict_features(directed[i]);
			if (want !== warm_want) $display("predictor warm-up disagrees");
			pending_features.push_back(warm_want);
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tdata <= {directed[i].volume, directed[i].close, directed[i].low,
				directed[i].high};
			s_tvalid <= 1'b1;
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		drain_results();

		for (int ph = 0; ph < 26; ph++) begin
			if (ph == 9) begin send_idle_pct = 57; recv_idle_pct = 34; end
			if (ph == 18) begin send_idle_pct = 0; recv_idle_pct = 0; end
			for (int r = 0; r < cfd_pkg::NumRegs; r++) begin
				if (ph == 0) write_weight(r[2:0], 16'h7FFF);
				else if (ph == 1) write_weight(r[2:0], 16'h8000);
				else write_weight(r[2:0], rand_weight());
			end
			cfg_valid <= 1'b0;
			if (ph == 4) hold_on = 1'b1;
			mode = ph % 4;
			for (int n = 0; n < 50; n++) begin
				cd = rand_candle($urandom_range(4) == 0 ? $urandom_range(3) : mode);
				send_candle(cd);
			end
			drain_results();
		end

		s_tvalid <= 1'b0;
		while (pending_features.size() != 0) @(negedge clk);
		repeat (500) @(negedge clk);
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
